>>> hdl/moving_average_filter_unit_macros.svh
// Assertion macros shared by the filter RTL.
// The clock is clk and the asynchronous reset is arst_n in every module that uses them.
`ifndef MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MAF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("moving average filter: assertion failed");
`define MAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("moving average filter: assertion failed");
`else
`define MAF_ASSERT_SAME(label, ante, cons)
`define MAF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/maf_pkg.sv
package maf_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 16;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int SUM_W      = SAMPLE_W + ADDR_W;
	localparam int CNT_W      = $clog2(SUM_W);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [ADDR_W-1:0]          addr_t;

	// Zero acts as one, anything above the store depth saturates to the depth.
	function automatic len_t effective_length(input len_t raw);
		len_t res;
		if (raw == '0) begin
			res = len_t'(1);
		end else if (raw > len_t'(MAX_WINDOW)) begin
			res = len_t'(MAX_WINDOW);
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

>>> hdl/moving_average_filter_unit.sv
// Boxcar moving average over signed 16-bit samples. Each accepted sample
// replaces the oldest of the last window_length samples, and one result
// transaction follows with the window sum divided by window_length, truncated
// toward zero; until the window has filled, the missing samples count as zero.
// The samples live in a 64-entry synchronous memory and a running sum is kept,
// so each sample costs one memory read and one write. The block works on one
// sample at a time: the result transaction is offered after a read state,
// in which the memory read settles, an update state, 22 steps of a bit-serial
// divider and an output state, and the next sample can be accepted only once
// the block is back in its idle state, so it never takes a new sample before
// it is through with the last one. A new sample is taken as soon as the
// previous result has moved into the output register, even if that result
// is still stalled downstream; a result that finds the output register still
// occupied waits in the output state and holds off the input.
// A write to window_length (values 0 and 1 both mean one sample, values above
// 64 mean 64) clears the window through per-entry valid flags; no
// clearing pass is needed after reset or a write.
// Only write window_length while the block is idle; cfg_ready is high then.
module moving_average_filter_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  maf_pkg::sample_t        sample_in,
	output logic                    average_valid,
	input  logic                    average_stall,
	output maf_pkg::sample_t        average_out,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  maf_pkg::len_t           window_length
);
	import maf_pkg::*;

	`include "moving_average_filter_unit_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	len_t                  eff_len_q;
	addr_t                 wpos_q;
	sum_t                  sum_q;
	logic [MAX_WINDOW-1:0] vld_q;

	// Sample and its store address travel together from acceptance onward.
	sample_t               sample_s1;
	addr_t                 pos_s1;

	// Sample memory with a registered read port.
	sample_t               mem [MAX_WINDOW];
	sample_t               rd_data_q;

	// Serial divider: magnitude register doubles as quotient shift register.
	logic [SUM_W-1:0]      div_q;
	len_t                  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;

	logic                  avg_valid_q;
	sample_t               avg_q;

	logic                  sample_acc;
	logic                  cfg_acc;
	logic                  out_free;
	addr_t                 pos_sel;
	sample_t               old_sample;
	sum_t                  new_sum;
	logic [SUM_W-1:0]      new_mag;
	logic [LEN_W:0]        rem_shift;
	logic                  quot_bit;
	len_t                  rem_next;
	logic [LEN_W-1:0]      pos_inc;
	logic [SUM_W-1:0]      quot_signed;

	// A configuration write takes priority, so no sample is taken in its cycle.
	assign cfg_ready    = (state_q == ST_IDLE);
	assign sample_stall = (state_q != ST_IDLE) || cfg_valid;
	assign sample_acc   = sample_valid && !sample_stall;
	assign cfg_acc      = cfg_valid && cfg_ready;
	assign out_free     = !avg_valid_q || !average_stall;

	assign average_valid = avg_valid_q;
	assign average_out   = avg_q;

	always_comb begin
		// The write position always lies inside the window; the guard maps any position outside it to zero.
		if (len_t'(wpos_q) >= eff_len_q) begin
			pos_sel = '0;
		end else begin
			pos_sel = wpos_q;
		end

		// An entry not written since the last clear reads as zero.
		old_sample = vld_q[pos_s1] ? rd_data_q : '0;
		new_sum    = sum_q - sum_t'(old_sample) + sum_t'(sample_s1);
		new_mag    = new_sum[SUM_W-1] ? (SUM_W)'(-new_sum) : (SUM_W)'(new_sum);

		pos_inc = len_t'(pos_s1) + len_t'(1);

		// One restoring step: remainder stays below the divisor.
		rem_shift = {rem_q, div_q[SUM_W-1]};
		quot_bit  = (rem_shift >= {1'b0, eff_len_q});
		if (quot_bit) begin
			rem_next = len_t'(rem_shift - {1'b0, eff_len_q});
		end else begin
			rem_next = rem_shift[LEN_W-1:0];
		end

		quot_signed = neg_q ? (SUM_W)'(-div_q) : div_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			mem[pos_s1] <= sample_s1;
		end
		if (sample_acc) begin
			rd_data_q <= mem[pos_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eff_len_q   <= len_t'(MAX_WINDOW);
			wpos_q      <= '0;
			sum_q       <= '0;
			vld_q       <= '0;
			avg_valid_q <= 1'b0;
			avg_q       <= '0;
			cnt_q       <= '0;
			sample_s1   <= '0;
			pos_s1      <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			neg_q       <= 1'b0;
		end else begin
			// A finished result enters the output register as the previous one
			// leaves or once the register is empty.
			if (state_q == ST_DONE && out_free) begin
				avg_valid_q <= 1'b1;
			end else if (average_valid && !average_stall) begin
				avg_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						eff_len_q <= effective_length(window_length);
						wpos_q    <= '0;
						sum_q     <= '0;
						vld_q     <= '0;
					end else if (sample_acc) begin
						sample_s1 <= sample_in;
						pos_s1    <= pos_sel;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q          <= new_sum;
					vld_q[pos_s1]  <= 1'b1;
					if (pos_inc >= eff_len_q) begin
						wpos_q <= '0;
					end else begin
						wpos_q <= pos_inc[ADDR_W-1:0];
					end
					div_q   <= new_mag;
					neg_q   <= new_sum[SUM_W-1];
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					div_q <= {div_q[SUM_W-2:0], quot_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						avg_q   <= quot_signed[SAMPLE_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MAF_ASSERT_SAME(a_wpos_in_window, 1'b1, len_t'(wpos_q) < eff_len_q)
	`MAF_ASSERT_SAME(a_rem_below_len, state_q == ST_DIV, rem_q < eff_len_q)
	`MAF_ASSERT_SAME(a_quot_fits, state_q == ST_DONE, div_q <= (SUM_W)'(32768))
	`MAF_ASSERT_NEXT(a_update_sets_valid, state_q == ST_UPDATE, vld_q[pos_s1])

endmodule
